>>> design/pol_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_pkg: shared types and codes for the positional ordered list
// Request kinds, result status codes and the control word for the cell chain.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 5;

  localparam logic [KIND_W-1:0] REQ_INS_FIRST = 3'd0;
  localparam logic [KIND_W-1:0] REQ_INS_LAST  = 3'd1;
  localparam logic [KIND_W-1:0] REQ_INS_POS   = 3'd2;
  localparam logic [KIND_W-1:0] REQ_DEL_FIRST = 3'd3;
  localparam logic [KIND_W-1:0] REQ_DEL_LAST  = 3'd4;
  localparam logic [KIND_W-1:0] REQ_DEL_POS   = 3'd5;
  localparam logic [KIND_W-1:0] REQ_READ      = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  data;
  } cell_ctl_t;

endpackage

>>> design/positional_ordered_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_ordered_list: bounded ordered list of signed 32-bit values
// Flow: an accepted item is held through the execute state, which loads its
// single result into the output register; a read-out passes on to the read
// state, which offers one entry per cycle from the cell chain head while the
// output register is free. A new item is taken only back in the idle state.
// The output register lets the next item in while a result waits.
// Reset (rst_n low, synchronous) empties the list and clears the handshakes.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pol_pkg::KIND_W-1:0]         in_req_type,
  input  logic signed [pol_pkg::DATA_W-1:0]  in_data_in,
  input  logic [pol_pkg::POS_W-1:0]          in_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pol_pkg::STATUS_W-1:0]       out_status,
  output logic signed [pol_pkg::DATA_W-1:0]  out_data_out,
  output logic [pol_pkg::TOTAL_W-1:0]        out_entry_total,
  output logic                               out_last
);
  import pol_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         rd_r;
  logic [KIND_W-1:0]        kind_r;
  logic signed [DATA_W-1:0] data_r;
  logic [POS_W-1:0]         pos_r;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      status_r;
  logic signed [DATA_W-1:0] dout_r;
  logic [CNT_W-1:0]         total_r;
  logic                     last_r;

  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  cell_ctl_t                ctl;
  logic [IDX_W-1:0]         idx;

  // request decode
  cell_op_t                 ex_op;
  logic [IDX_W-1:0]         ex_idx;
  logic [STATUS_W-1:0]      ex_status;
  logic [CNT_W-1:0]         ex_count_nxt;
  logic                     ex_read;
  logic                     full;
  logic [CMP_W-1:0]         pos_e;
  logic [CMP_W-1:0]         cnt_e;
  logic [CMP_W-1:0]         pos_m1;
  logic [CNT_W-1:0]         cnt_m1;

  logic                     out_free;
  logic                     exec_fire;
  logic                     read_fire;
  logic                     read_end;
  logic                     out_load;
  logic [CNT_W+TOTAL_W-1:0] total_ext;

  assign out_free  = !out_valid_r || out_ready;
  assign exec_fire = (state_r == S_EXEC) && out_free;
  assign read_fire = (state_r == S_READ) && out_free;
  assign read_end  = (rd_r == cnt_m1);
  assign out_load  = (exec_fire && !ex_read) || read_fire;

  assign full   = (count_r == CNT_W'(CAPACITY));
  assign pos_e  = CMP_W'(pos_r);
  assign cnt_e  = CMP_W'(count_r);
  assign pos_m1 = pos_e - CMP_W'(1);
  assign cnt_m1 = count_r - CNT_W'(1);

  always_comb begin
    ex_op        = OP_HOLD;
    ex_idx       = '0;
    ex_status    = ST_OK;
    ex_count_nxt = count_r;
    ex_read      = 1'b0;
    case (kind_r)
      REQ_INS_FIRST: begin
        if (full) begin
          ex_status = ST_FULL;
        end else begin
          ex_op        = OP_INS;
          ex_count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_INS_LAST: begin
        if (full) begin
          ex_status = ST_FULL;
        end else begin
          ex_op        = OP_INS;
          ex_idx       = count_r[IDX_W-1:0];
          ex_count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_INS_POS: begin
        if (pos_e == '0 || pos_e > cnt_e + CMP_W'(1)) begin
          ex_status = ST_BADPOS;
        end else if (full) begin
          ex_status = ST_FULL;
        end else begin
          ex_op        = OP_INS;
          ex_idx       = pos_m1[IDX_W-1:0];
          ex_count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_DEL_FIRST: begin
        if (count_r == '0) begin
          ex_status = ST_EMPTY;
        end else begin
          ex_op        = OP_DEL;
          ex_count_nxt = cnt_m1;
        end
      end
      REQ_DEL_LAST: begin
        if (count_r == '0) begin
          ex_status = ST_EMPTY;
        end else begin
          ex_op        = OP_DEL;
          ex_idx       = cnt_m1[IDX_W-1:0];
          ex_count_nxt = cnt_m1;
        end
      end
      REQ_DEL_POS: begin
        if (pos_e == '0 || pos_e > cnt_e) begin
          ex_status = ST_BADPOS;
        end else begin
          ex_op        = OP_DEL;
          ex_idx       = pos_m1[IDX_W-1:0];
          ex_count_nxt = cnt_m1;
        end
      end
      REQ_READ: begin
        if (count_r == '0) begin
          ex_status = ST_EMPTY;
        end else begin
          ex_read = 1'b1;
        end
      end
      default: ex_op = OP_HOLD;
    endcase
  end

  always_comb begin
    ctl.data = data_r;
    idx      = ex_idx;
    if (exec_fire) begin
      ctl.op = ex_op;
    end else if (read_fire) begin
      ctl.op = OP_ROT;
    end else begin
      ctl.op = OP_HOLD;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_q;
    logic signed [DATA_W-1:0] right_q;
    if (g == 0) begin : g_head
      assign left_q = '0;
    end else begin : g_body
      assign left_q = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_q = '0;
    end else begin : g_mid
      assign right_q = cell_q[g+1];
    end
    pol_cell #(
      .SLOT  (g),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (idx),
      .count   (count_r),
      .left_q  (left_q),
      .right_q (right_q),
      .head_q  (cell_q[0]),
      .q       (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r  <= in_req_type;
            data_r  <= in_data_in;
            pos_r   <= in_position;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            count_r <= ex_count_nxt;
            if (ex_read) begin
              rd_r    <= '0;
              state_r <= S_READ;
            end else begin
              status_r    <= ex_status;
              dout_r      <= '0;
              total_r     <= ex_count_nxt;
              last_r      <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        S_READ: begin
          if (out_free) begin
            // emit the head entry and rotate the next one into place
            status_r    <= ST_OK;
            dout_r      <= cell_q[0];
            total_r     <= count_r;
            last_r      <= read_end;
            rd_r        <= rd_r + CNT_W'(1);
            if (read_end) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign total_ext = {{TOTAL_W{1'b0}}, total_r};

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_data_out    = dout_r;
  assign out_entry_total = total_ext[TOTAL_W-1:0];
  assign out_last        = last_r;

endmodule

>>> design/pol_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_cell: one slot of the ordered list
// Holds one entry and decides from its own place whether to keep it, take the
// new value, take its left or right neighbor, or wrap the head value around.
// ----------------------------------------------------------------------------
module pol_cell #(
  parameter int SLOT   = 0,
  parameter int IDX_W  = 4,
  parameter int CNT_W  = 5
) (
  input  logic                          clk,
  input  pol_pkg::cell_ctl_t            ctl,
  input  logic [IDX_W-1:0]              idx,
  input  logic [CNT_W-1:0]              count,
  input  logic signed [pol_pkg::DATA_W-1:0] left_q,
  input  logic signed [pol_pkg::DATA_W-1:0] right_q,
  input  logic signed [pol_pkg::DATA_W-1:0] head_q,
  output logic signed [pol_pkg::DATA_W-1:0] q
);
  import pol_pkg::*;

  localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(SLOT);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(SLOT + 1);

  logic signed [DATA_W-1:0] q_r;
  logic signed [DATA_W-1:0] q_nxt;
  logic [CNT_W-1:0]         idx_e;

  assign idx_e = CNT_W'(idx);

  always_comb begin
    q_nxt = q_r;
    case (ctl.op)
      OP_INS: begin
        if (MY_POS == idx_e) begin
          q_nxt = ctl.data;
        end else if (MY_POS > idx_e && MY_POS <= count) begin
          q_nxt = left_q;
        end
      end
      OP_DEL: begin
        if (MY_POS >= idx_e && MY_NEXT < count) begin
          q_nxt = right_q;
        end
      end
      OP_ROT: begin
        // rotate the occupied part of the chain by one toward the head
        if (MY_NEXT < count) begin
          q_nxt = right_q;
        end else if (MY_NEXT == count) begin
          q_nxt = head_q;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

>>> design/pol_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_checker: port-level checks for the positional ordered list
// Watches the result channel for stalls and for consistent status fields.
// ----------------------------------------------------------------------------
module pol_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [pol_pkg::STATUS_W-1:0]       out_status,
  input  logic signed [pol_pkg::DATA_W-1:0]  out_data_out,
  input  logic [pol_pkg::TOTAL_W-1:0]        out_entry_total,
  input  logic                               out_last
);
  import pol_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // any non-ok status ends its request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("error status not marked last");

  // data is zero on a non-ok status, which only comes outside read-out
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_data_out == '0)
    else $error("non-zero data on error status");

  // empty status only with an empty list
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entry_total == '0)
    else $error("empty status with entries present");

  // no new item while the result of a non-last read-out entry is pending
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("item accepted during read-out");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for positional_ordered_list
// Feeds list requests (directed corner cases, then phased random fill, drain
// and mixed traffic) through a valid/ready driver, keeps a queue-based shadow
// of the list to work out every expected result, and compares each result
// item field by field as the monitor takes it. Both sides idle at random and
// the receiver holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import pol_pkg::*;

  localparam int LIST_CAP     = 16;
  localparam int RANDOM_ITEMS = 147;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 40;
  localparam int HOLD_AT      = 70;
  localparam int HOLD_CYCLES  = 60;
  localparam int CALM_ITEMS   = 30;
  localparam logic [KIND_W-1:0] REQ_UNUSED = 3'd7;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
  } list_req_t;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] value;
    logic [TOTAL_W-1:0]       total;
    logic                     last;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [KIND_W-1:0]         in_req_type = '0;
  logic signed [DATA_W-1:0]  in_data_in = '0;
  logic [POS_W-1:0]          in_position = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STATUS_W-1:0]       out_status;
  logic signed [DATA_W-1:0]  out_data_out;
  logic [TOTAL_W-1:0]        out_entry_total;
  logic                      out_last;

  list_req_t                 request_q[$];
  list_result_t              awaited_results[$];
  logic signed [DATA_W-1:0]  shadow_list[$];

  int  gen_count = 0;
  int  total_items = 0;
  int  items_accepted = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  backpressure_left = 0;
  bit  hold_done = 1'b0;
  logic idle_allowed;

  positional_ordered_list #(.CAPACITY(LIST_CAP)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_data_in      (in_data_in),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_entry_total (out_entry_total),
    .out_last        (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // no idling in every third stretch of 16 items, nor near the end
  assign idle_allowed = (items_accepted < total_items - CALM_ITEMS) &&
                        (((items_accepted / 16) % 3) != 2);

  // Shadow of the list: apply one request and queue the results it causes.
  function automatic void predict_list_request(list_req_t r);
    logic [STATUS_W-1:0] st;
    int n;
    n  = shadow_list.size();
    st = ST_OK;
    case (r.kind)
      REQ_INS_FIRST: begin
        if (n >= LIST_CAP) st = ST_FULL;
        else shadow_list.push_front(r.value);
      end
      REQ_INS_LAST: begin
        if (n >= LIST_CAP) st = ST_FULL;
        else shadow_list.push_back(r.value);
      end
      REQ_INS_POS: begin
        if (int'(r.pos) < 1 || int'(r.pos) > n + 1) st = ST_BADPOS;
        else if (n >= LIST_CAP) st = ST_FULL;
        else shadow_list.insert(int'(r.pos) - 1, r.value);
      end
      REQ_DEL_FIRST: begin
        if (n == 0) st = ST_EMPTY;
        else void'(shadow_list.pop_front());
      end
      REQ_DEL_LAST: begin
        if (n == 0) st = ST_EMPTY;
        else void'(shadow_list.pop_back());
      end
      REQ_DEL_POS: begin
        if (int'(r.pos) < 1 || int'(r.pos) > n) st = ST_BADPOS;
        else shadow_list.delete(int'(r.pos) - 1);
      end
      REQ_READ: begin
        if (n == 0) st = ST_EMPTY;
        else begin
          for (int i = 0; i < n; i++)
            awaited_results.push_back('{ST_OK, shadow_list[i], TOTAL_W'(n), i == n - 1});
          return;
        end
      end
      default: ;
    endcase
    awaited_results.push_back('{st, '0, TOTAL_W'(shadow_list.size()), 1'b1});
  endfunction

  function automatic void check_field(string field, logic signed [DATA_W-1:0] want,
                                      logic signed [DATA_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // Queue one request and track the entry count it leaves, to steer the mix.
  task automatic queue_request(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] value,
                               logic [POS_W-1:0] pos);
    request_q.push_back('{kind, value, pos});
    case (kind)
      REQ_INS_FIRST, REQ_INS_LAST: if (gen_count < LIST_CAP) gen_count++;
      REQ_INS_POS:
        if (pos >= 1 && int'(pos) <= gen_count + 1 && gen_count < LIST_CAP) gen_count++;
      REQ_DEL_FIRST, REQ_DEL_LAST: if (gen_count > 0) gen_count--;
      REQ_DEL_POS: if (pos >= 1 && int'(pos) <= gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    v = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7fff_ffff;
        2: v = '0;
        default: v = -1;
      endcase
    end
    return v;
  endfunction

  // mostly a position in range for the current count, sometimes anything
  function automatic logic [POS_W-1:0] pick_pos(bit for_insert);
    int top;
    top = for_insert ? gen_count + 1 : gen_count;
    if (top < 1 || $urandom_range(0, 99) < 15) return POS_W'($urandom_range(0, 31));
    return POS_W'($urandom_range(1, top));
  endfunction

  // driver
  always @(posedge clk) begin : feed
    list_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_list_request('{in_req_type, in_data_in, in_position});
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0 && idle_allowed && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          nxt = request_q.pop_front();
          in_req_type <= nxt.kind;
          in_data_in  <= nxt.value;
          in_position <= nxt.pos;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      backpressure_left <= 0;
    end else if (!hold_done && items_accepted >= HOLD_AT) begin
      backpressure_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (backpressure_left != 0) begin
      backpressure_left <= backpressure_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    list_result_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result item: status %0d data %0d total %0d last %0d",
                   $time, out_status, out_data_out, out_entry_total, out_last);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(out_status));
          check_field("data_out", want.value, out_data_out);
          check_field("entry_total", DATA_W'(want.total), DATA_W'(out_entry_total));
          check_field("last", DATA_W'(want.last), DATA_W'(out_last));
        end
      end
      if (backpressure_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (idle_allowed && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 2);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d result items still awaited", $time, awaited_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int rand_made;
    int phase;
    int span;
    int roll;

    // empty list corner cases
    queue_request(REQ_READ, pick_value(), 5'd0);
    queue_request(REQ_DEL_FIRST, pick_value(), 5'd0);
    queue_request(REQ_DEL_LAST, pick_value(), 5'd31);
    queue_request(REQ_DEL_POS, pick_value(), 5'd1);
    queue_request(REQ_UNUSED, pick_value(), 5'd3);
    queue_request(REQ_INS_POS, 32'sd7, 5'd0);
    queue_request(REQ_INS_POS, 32'sd7, 5'd2);
    // build a short list with extreme values
    queue_request(REQ_INS_FIRST, 32'sh8000_0000, 5'd0);
    queue_request(REQ_INS_LAST, 32'sh7fff_ffff, 5'd31);
    queue_request(REQ_INS_POS, 32'sd0, 5'd2);
    queue_request(REQ_INS_POS, -32'sd1, 5'd4);
    queue_request(REQ_INS_POS, 32'sd9, 5'd31);
    queue_request(REQ_READ, pick_value(), 5'd0);
    queue_request(REQ_DEL_POS, pick_value(), 5'd0);
    queue_request(REQ_DEL_POS, pick_value(), 5'd5);
    queue_request(REQ_DEL_POS, pick_value(), 5'd4);
    queue_request(REQ_DEL_POS, pick_value(), 5'd1);
    queue_request(REQ_UNUSED, pick_value(), 5'd31);
    queue_request(REQ_DEL_LAST, pick_value(), 5'd0);
    queue_request(REQ_DEL_FIRST, pick_value(), 5'd0);
    queue_request(REQ_READ, pick_value(), 5'd0);
    queue_request(REQ_INS_POS, 32'sh5555_5555, 5'd1);
    queue_request(REQ_READ, pick_value(), 5'd0);

    // random phases: fill toward full, drain toward empty, then anything
    rand_made = 0;
    phase = 0;
    while (rand_made < RANDOM_ITEMS) begin
      span = $urandom_range(15, 35);
      if (span > RANDOM_ITEMS - rand_made) span = RANDOM_ITEMS - rand_made;
      repeat (span) begin
        roll = $urandom_range(0, 99);
        case (phase % 3)
          0: begin
            if (roll < 25) queue_request(REQ_INS_FIRST, pick_value(), pick_pos(1));
            else if (roll < 45) queue_request(REQ_INS_LAST, pick_value(), pick_pos(1));
            else if (roll < 70) queue_request(REQ_INS_POS, pick_value(), pick_pos(1));
            else if (roll < 80) queue_request(REQ_READ, pick_value(), pick_pos(0));
            else if (roll < 90)
              queue_request(KIND_W'($urandom_range(0, 7)), pick_value(),
                            POS_W'($urandom_range(0, 31)));
            else queue_request(REQ_DEL_POS, pick_value(), pick_pos(0));
          end
          1: begin
            if (roll < 25) queue_request(REQ_DEL_FIRST, pick_value(), pick_pos(0));
            else if (roll < 45) queue_request(REQ_DEL_LAST, pick_value(), pick_pos(0));
            else if (roll < 70) queue_request(REQ_DEL_POS, pick_value(), pick_pos(0));
            else if (roll < 80) queue_request(REQ_READ, pick_value(), pick_pos(0));
            else if (roll < 90)
              queue_request(KIND_W'($urandom_range(0, 7)), pick_value(),
                            POS_W'($urandom_range(0, 31)));
            else queue_request(REQ_INS_POS, pick_value(), pick_pos(1));
          end
          default: begin
            queue_request(KIND_W'($urandom_range(0, 7)), pick_value(),
                          pick_pos(1'($urandom_range(0, 1))));
          end
        endcase
        rand_made++;
      end
      phase++;
    end
    total_items = request_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // sample away from the active edge so the driver's updates have settled
    while (request_q.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
